@@ src/swa_pkg.sv @@
package swa_pkg;

   // Width and reset value of the window length register.
   localparam int WLEN_BITS = 9;
   localparam logic [WLEN_BITS-1:0] WLEN_RESET = 9'd16;

   // Status that the divider reports back to the controller.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ src/swa_sample_if.sv @@
interface swa_sample_if #(
   parameter int BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic signed [BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

@@ src/swa_average_if.sv @@
interface swa_average_if #(
   parameter int BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic signed [BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink (input valid, input average, output ready);
endinterface

@@ src/swa_ram.sv @@
module swa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data <= mem_ff[read_address];
   end
endmodule

@@ src/swa_divider.sv @@
module swa_divider #(
   parameter int DIVIDEND_BITS = 24,
   parameter int DIVISOR_BITS  = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]         divisor,
   output logic signed [DIVIDEND_BITS-1:0] quotient,
   output swa_pkg::div_status_type         status
);
   import swa_pkg::*;

   localparam int COUNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIX
   } state_type;

   state_type                state_ff, state_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  divisor_ff, divisor_in;
   logic                     neg_ff, neg_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic signed [DIVIDEND_BITS-1:0] result_ff, result_in;
   logic                     done_ff, done_in;

   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    trial;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign shifted = {rem_ff, quot_ff[DIVIDEND_BITS-1]};
   assign trial   = shifted - {1'b0, divisor_ff};

   always_comb begin
      state_in   = state_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      count_in   = count_ff;
      result_in  = result_ff;
      done_in    = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               neg_in     = dividend[DIVIDEND_BITS-1];
               quot_in    = dividend[DIVIDEND_BITS-1] ? -dividend : dividend;
               rem_in     = '0;
               divisor_in = divisor;
               count_in   = COUNT_BITS'(DIVIDEND_BITS - 1);
               state_in   = D_RUN;
            end
         end
         D_RUN: begin
            if (!trial[DIVISOR_BITS]) begin
               rem_in  = trial[DIVISOR_BITS-1:0];
               quot_in = {quot_ff[DIVIDEND_BITS-2:0], 1'b1};
            end else begin
               rem_in  = shifted[DIVISOR_BITS-1:0];
               quot_in = {quot_ff[DIVIDEND_BITS-2:0], 1'b0};
            end
            count_in = count_ff - COUNT_BITS'(1);
            if (count_ff == '0) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            // Truncation toward zero: divide the magnitude, then restore the sign.
            result_in = neg_ff ? -signed'(quot_ff) : signed'(quot_ff);
            done_in   = 1'b1;
            state_in  = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
      result_ff  <= result_in;
   end

   assign quotient    = result_ff;
   assign status.busy = (state_ff != D_IDLE);
   assign status.done = done_ff;

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_IDLE && start) |=> (state_ff == D_RUN))
      else $error("divider did not start");

   a_done_after_fix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == D_FIX))
      else $error("divider done without final step");

   a_count_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_RUN && count_ff == '0) |=> (state_ff == D_FIX))
      else $error("divider overran its step count");
endmodule

@@ src/sliding_window_average.sv @@
// Boxcar moving average over signed samples.
// The req channel takes one sample per word (valid/ready). The rsp channel
// gives one average per word once the window holds window_len samples;
// before that a sample is absorbed and gives no word.
// csr_write_enable with csr_write_data sets window_len and clears the window:
// the write pointer, fill count and running sum, so that stale ring buffer
// words count as zero. A length of zero acts as one, and a length above
// MAX_WINDOW acts as MAX_WINDOW. A sample that yields an average goes through
// these steps after acceptance: S_UPDATE updates the ring buffer and the
// running sum, S_START launches the divider, which makes SUM_BITS restoring
// steps at one quotient bit per cycle, restores the sign and raises its done
// flag, and S_HOLD loads the output register once it is free. rsp.valid rises
// in the same cycle that req.ready comes back high, and one divider serves
// every sample, so a new sample is taken only once the last one is through.
// req.ready is high only while no sample is at work. A sample that produces
// no average is accepted, updates the window in S_UPDATE and leaves the block idle.
// If the receiver stalls, the average waits in the output register and the
// next finished average waits in the divider until the register frees up.
// Reset (synchronous, active high) sets window_len to 16, empties the window
// and drops any word in flight. No clearing pass is needed.
module sliding_window_average #(
   parameter int MAX_WINDOW  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [swa_pkg::WLEN_BITS-1:0]    csr_write_data,
   swa_sample_if.sink                       req,
   swa_average_if.source                    rsp
);
   import swa_pkg::*;

   localparam int PTR_BITS = $clog2(MAX_WINDOW);
   localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_START,
      S_DIVIDE,
      S_HOLD
   } state_type;

   function automatic logic [LEN_BITS-1:0] sat_len(input logic [WLEN_BITS-1:0] value);
      int n;
      n = int'(value);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_WINDOW) begin
         n = MAX_WINDOW;
      end
      return LEN_BITS'(n);
   endfunction

   state_type                     state_ff, state_in;
   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic [PTR_BITS-1:0]           wp_ff, wp_in;
   logic [LEN_BITS-1:0]           fill_ff, fill_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] average_ff, average_in;

   logic                          ram_write;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic                          full;
   logic [SAMPLE_BITS-1:0]        old_sample;
   logic signed [SUM_BITS-1:0]    old_ext, new_ext, sum_next;
   logic [LEN_BITS-1:0]           wp_plus, fill_plus;
   logic                          div_start;
   logic signed [SUM_BITS-1:0]    div_quotient;
   div_status_type                div_status;

   swa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock         (clock),
      .write_enable  (ram_write),
      .write_address (wp_ff),
      .write_data    (sample_ff),
      .read_address  (wp_ff),
      .read_data     (ram_rdata)
   );

   swa_divider #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (LEN_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (len_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Until the window has filled once since the last clear, the slot being
   // overwritten was never written and counts as zero.
   assign full       = (fill_ff == len_ff);
   assign old_sample = full ? ram_rdata : '0;
   assign old_ext    = signed'({{(SUM_BITS-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}},
                                old_sample});
   assign new_ext    = signed'({{(SUM_BITS-SAMPLE_BITS){sample_ff[SAMPLE_BITS-1]}},
                                sample_ff});
   assign sum_next   = sum_ff - old_ext + new_ext;
   assign wp_plus    = LEN_BITS'(wp_ff) + LEN_BITS'(1);
   assign fill_plus  = fill_ff + LEN_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff;
      average_in   = average_ff;
      ram_write    = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               sample_in = req.sample;
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ram_write = 1'b1;
            sum_in    = sum_next;
            wp_in     = (wp_plus == len_ff) ? '0 : wp_plus[PTR_BITS-1:0];
            fill_in   = full ? fill_ff : fill_plus;
            state_in  = (full || fill_plus == len_ff) ? S_START : S_IDLE;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp.ready) begin
               average_in   = div_quotient[SAMPLE_BITS-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         len_in  = sat_len(csr_write_data);
         wp_in   = '0;
         fill_in = '0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= sat_len(WLEN_RESET);
         wp_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      average_ff <= average_in;
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.average = average_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("fill count exceeds window length");

   a_pointer_bound: assert property (@(posedge clock) disable iff (reset)
      LEN_BITS'(wp_ff) < len_ff)
      else $error("write pointer outside window");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside the divide state");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |=> div_status.busy)
      else $error("divider did not take the start");

   a_word_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_HOLD))
      else $error("result word raised outside the hold state");
endmodule

@@ tb/sliding_window_average_test.sv @@
module sliding_window_average_test;
   import swa_pkg::*;

   localparam int MAX_SPAN      = 256;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 600000;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_CONFIG,
      OP_DRAIN
   } stim_kind_type;

   typedef struct {
      stim_kind_type        kind;
      logic [15:0]          sample;
      logic [WLEN_BITS-1:0] value;
   } stim_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable;
   logic [WLEN_BITS-1:0] csr_write_data;

   swa_sample_if  #(.BITS(16)) req_if ();
   swa_average_if #(.BITS(16)) rsp_if ();

   sliding_window_average #(
      .MAX_WINDOW (MAX_SPAN),
      .SAMPLE_BITS(16)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req             (req_if),
      .rsp             (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stim_item_type      pending[$];
   logic signed [15:0] expected_avg[$];
   int                 error_count  = 0;
   int                 cycle_count  = 0;
   int                 quiet_cycles = 0;
   int                 gap_left     = 0;
   int                 stall_left   = 0;
   bit                 word_taken   = 1'b0;

   // Shadow copy of the window: ring, write position, fill level and exact sum.
   logic signed [15:0]   ring_model[MAX_SPAN];
   int unsigned          ring_pos;
   int unsigned          ring_fill;
   longint               ring_sum;
   logic [WLEN_BITS-1:0] len_reg;

   function automatic void clear_ring();
      for (int i = 0; i < MAX_SPAN; i++) begin
         ring_model[i] = '0;
      end
      ring_pos  = 0;
      ring_fill = 0;
      ring_sum  = 0;
   endfunction

   function automatic int unsigned window_span();
      int unsigned n;
      n = 32'(len_reg);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_SPAN) begin
         n = MAX_SPAN;
      end
      return n;
   endfunction

   function automatic bit absorb_sample(input logic signed [15:0] s,
                                        output logic signed [15:0] avg);
      int unsigned span;
      int unsigned pos;
      span = window_span();
      pos  = ring_pos;
      avg  = '0;
      if (pos >= span) begin
         pos = 0;
      end
      ring_sum        = ring_sum - ring_model[pos] + s;
      ring_model[pos] = s;
      pos++;
      if (pos >= span) begin
         pos = 0;
      end
      ring_pos = pos;
      if (ring_fill < span) begin
         ring_fill++;
      end
      if (ring_fill < span) begin
         return 1'b0;
      end
      avg = 16'(ring_sum / longint'(span));
      return 1'b1;
   endfunction

   // Idling is switched off near the end and over some middle stretches.
   function automatic bit calm_stretch();
      return (pending.size() < 80) || ((pending.size() / 96) % 3 == 0);
   endfunction

   function automatic logic [15:0] rand_sample();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         return 16'h7FFF;
      end
      if (pick < 4) begin
         return 16'h8000;
      end
      if (pick < 7) begin
         return 16'($signed($urandom_range(0, 6)) - 3);
      end
      return 16'($urandom());
   endfunction

   task automatic push_sample(input logic [15:0] v);
      stim_item_type it;
      it.kind   = OP_SAMPLE;
      it.sample = v;
      it.value  = '0;
      pending.push_back(it);
   endtask

   task automatic push_config(input logic [WLEN_BITS-1:0] v);
      stim_item_type it;
      it.kind   = OP_CONFIG;
      it.sample = '0;
      it.value  = v;
      pending.push_back(it);
   endtask

   task automatic push_drain();
      stim_item_type it;
      it.kind   = OP_DRAIN;
      it.sample = '0;
      it.value  = '0;
      pending.push_back(it);
   endtask

   // Sender: presents words from the pending queue and performs idle-time writes.
   always @(negedge clock) begin : drive_req
      logic                 nxt_valid;
      logic [15:0]          nxt_sample;
      logic                 nxt_we;
      logic [WLEN_BITS-1:0] nxt_wdata;
      nxt_valid  = req_if.valid;
      nxt_sample = req_if.sample;
      nxt_we     = 1'b0;
      nxt_wdata  = csr_write_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_if.valid && word_taken) begin
            nxt_valid  = 1'b0;
            word_taken = 1'b0;
            pending.delete(0);
            if (!calm_stretch() && $urandom_range(0, 2) == 0) begin
               gap_left = $urandom_range(1, 8);
            end
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() > 0) begin
               case (pending[0].kind)
                  OP_SAMPLE: begin
                     nxt_valid  = 1'b1;
                     nxt_sample = pending[0].sample;
                  end
                  OP_CONFIG: begin
                     // A word that gives no average may still be inside the block.
                     if (expected_avg.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                        nxt_we    = 1'b1;
                        nxt_wdata = pending[0].value;
                        pending.delete(0);
                     end
                  end
                  OP_DRAIN: begin
                     if (expected_avg.size() == 0) begin
                        pending.delete(0);
                     end
                  end
                  default: begin
                     pending.delete(0);
                  end
               endcase
            end
         end
      end
      req_if.valid     <= nxt_valid;
      req_if.sample    <= nxt_sample;
      csr_write_enable <= nxt_we;
      csr_write_data   <= nxt_wdata;
   end

   // Receiver: ready with random stall bursts.
   always @(negedge clock) begin : drive_rsp
      if (reset || calm_stretch()) begin
         stall_left = 0;
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch_ports
      logic signed [15:0] want;
      logic signed [15:0] got;
      if (reset) begin
         len_reg = WLEN_RESET;
         clear_ring();
         word_taken   = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (quiet_cycles < 1000) begin
            quiet_cycles++;
         end
         if (csr_write_enable) begin
            len_reg = csr_write_data;
            clear_ring();
         end
         if (req_if.valid && req_if.ready) begin
            word_taken   = 1'b1;
            quiet_cycles = 0;
            if (absorb_sample(req_if.sample, want)) begin
               expected_avg.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            got = rsp_if.average;
            if (expected_avg.size() == 0) begin
               $display("%0t: unexpected average word, expected none, actual %0d",
                        $time, got);
               error_count++;
            end else begin
               want = expected_avg.pop_front();
               if (got !== want) begin
                  $display("%0t: average mismatch, expected %0d, actual %0d",
                           $time, want, got);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d words pending, %0d averages outstanding",
                  $time, pending.size(), expected_avg.size());
         $display("** sliding_window_average: FAILED **");
         $finish;
      end
   end

   initial begin : run_test
      int          random_count;
      int unsigned span;
      int unsigned n;
      int unsigned pick;
      logic [WLEN_BITS-1:0] len;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      rsp_if.ready     = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;

      // Reset length of sixteen, then a drain so the sender waits on the block.
      repeat (24) push_sample(rand_sample());
      push_drain();

      // Window of one: every word comes straight back.
      push_config(9'd1);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h0000);
      push_sample(16'hFFFF);
      push_sample(16'h0001);
      // Length zero acts as one.
      push_config(9'd0);
      push_sample(16'h8000);
      push_sample(16'h7FFF);
      // Truncation toward zero on odd negative and positive sums.
      push_config(9'd2);
      push_sample(16'hFFFF);
      push_sample(16'h0000);
      push_sample(16'hFFFD);
      push_sample(16'h0003);
      push_sample(16'h8000);
      push_sample(16'h8000);
      push_config(9'd3);
      push_sample(16'h0005);
      push_sample(16'hFFFF);
      push_sample(16'h7FFF);
      push_sample(16'h7FFF);
      push_drain();

      // Full window at the largest sum of each sign.
      push_config(9'd256);
      repeat (256) push_sample(16'h7FFF);
      repeat (6) push_sample(16'h8000);
      // A length above the maximum saturates to it.
      push_config(9'd511);
      repeat (256) push_sample(16'h8000);
      repeat (4) push_sample(rand_sample());

      random_count = 0;
      while (random_count < 180) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       len = '0;
            6, 7:    len = WLEN_BITS'($urandom_range(9, 32));
            8:       len = WLEN_BITS'($urandom_range(33, 96));
            9:       len = WLEN_BITS'(1);
            default: len = WLEN_BITS'($urandom_range(1, 8));
         endcase
         push_config(len);
         span = (len == '0) ? 1 : 32'(len);
         n    = span + $urandom_range(4, 30);
         for (int i = 0; i < n; i++) begin
            push_sample(rand_sample());
            if ($urandom_range(0, 49) == 0) begin
               push_drain();
            end
         end
         random_count += n;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending.size() != 0 || expected_avg.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_avg.size() != 0) begin
         $display("%0t: %0d averages never arrived", $time, expected_avg.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("** sliding_window_average: PASSED **");
      end else begin
         $display("** sliding_window_average: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/swa_pkg.sv
src/swa_sample_if.sv
src/swa_average_if.sv
src/swa_ram.sv
src/swa_divider.sv
src/sliding_window_average.sv
tb/sliding_window_average_test.sv
